// ===== design/dense_matrix_vector_multiply_unit_defines.svh =====
`ifndef DENSE_MATRIX_VECTOR_MULTIPLY_UNIT_DEFINES_SVH
`define DENSE_MATRIX_VECTOR_MULTIPLY_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define DMVM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define DMVM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/dmvm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dmvm_pkg;

  localparam logic CMD_MATRIX = 1'b0;
  localparam logic CMD_VECTOR = 1'b1;

  localparam logic [5:0] SIZE_RESET = 6'd32;

  typedef struct packed {
    logic               cmd;
    logic [4:0]         row_index;
    logic [4:0]         col_index;
    logic signed [31:0] data_value;
    logic               final_element;
  } in_word_t;

  typedef struct packed {
    logic [4:0]         out_row;
    logic signed [31:0] product_value;
    logic               saturated;
    logic               last_row;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

endpackage

`default_nettype wire

// ===== design/dense_matrix_vector_multiply_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "dense_matrix_vector_multiply_unit_defines.svh"

// Dense y = M*x over an n x n signed fixed-point matrix (n = matrix_size,
// capped at MAX_SIZE and 32). A matrix entry write or a vector element load is
// taken while start is high and busy is low. A vector load with final_element
// set starts the product if n > 0: busy rises, and one multiply-accumulate unit
// fed by a single read port of the matrix memory takes one matrix entry per
// cycle. Rows come out in order, row n-1 flagged by last_row. Each row is on
// result for exactly one cycle, marked by result_strobe; there is no way to
// stall it, so the receiver must take every strobed word as it comes. The
// size register takes a write only while the block is idle and start is low.
// Stores need no clearing after reset, but an entry read before it was ever
// written gives an undefined row value.
module dense_matrix_vector_multiply_unit #(
  parameter int MAX_SIZE  = 32,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire dmvm_pkg::in_word_t   item,
  output logic                      result_strobe,
  output dmvm_pkg::out_word_t       result,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [5:0]           cfg_data
);
  import dmvm_pkg::*;

  localparam int EFF_SIZE = (MAX_SIZE < 32) ? MAX_SIZE : 32;
  localparam int IDX_W    = (EFF_SIZE > 1) ? $clog2(EFF_SIZE) : 1;
  localparam int VDEPTH   = 1 << IDX_W;
  localparam int MDEPTH   = 1 << (2 * IDX_W);

  localparam logic signed [63:0] Q_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] Q_MIN = -64'sh0000_0000_8000_0000;
  localparam logic signed [63:0] A_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] A_MIN = 64'sh8000_0000_0000_0000;

  logic signed [31:0] mat_mem [MDEPTH];
  logic signed [31:0] vec_mem [VDEPTH];

  logic [5:0]       matrix_size;
  logic [5:0]       n_eff;
  logic [5:0]       n_last;
  state_t           state, state_next;
  logic             accept;
  logic             issue;
  logic             row_end;
  logic             prod_end;
  logic [IDX_W-1:0] ri, cj;

  // read stage
  logic               rd_valid, rd_first, rd_last;
  logic [4:0]         rd_row;
  logic signed [31:0] m_q, v_q;
  // multiply stage
  logic               mul_valid, mul_first, mul_last;
  logic [4:0]         mul_row;
  logic signed [63:0] prod_w, mul_p;
  // accumulate stage
  logic               acc_done;
  logic [4:0]         acc_row;
  logic               acc_final;
  logic signed [63:0] acc, acc_next;
  logic               stuck_pos, stuck_neg;
  logic               stuck_pos_next, stuck_neg_next;
  logic signed [63:0] base, sum;
  logic               base_pos, base_neg;
  // round and clip
  logic signed [63:0] acc_fixed, shifted;
  logic               clip_hi, clip_lo;

  assign cfg_ready = !busy && !start;
  assign n_eff  = (matrix_size > 6'(EFF_SIZE)) ? 6'(EFF_SIZE) : matrix_size;
  assign n_last = n_eff - 6'd1;
  assign accept = start && !busy;
  assign row_end  = (6'(cj) == n_last);
  assign prod_end = row_end && (6'(ri) == n_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      matrix_size <= cfg_data;
    end
  end

  // store writes
  always_ff @(posedge clk) begin
    if (accept) begin
      if (item.cmd == CMD_MATRIX) begin
        if (({1'b0, item.row_index} < 6'(EFF_SIZE)) &&
            ({1'b0, item.col_index} < 6'(EFF_SIZE))) begin
          mat_mem[{item.row_index[IDX_W-1:0], item.col_index[IDX_W-1:0]}] <= item.data_value;
        end
      end else if ({1'b0, item.col_index} < 6'(EFF_SIZE)) begin
        vec_mem[item.col_index[IDX_W-1:0]] <= item.data_value;
      end
    end
  end

  // store reads
  always_ff @(posedge clk) begin
    m_q <= mat_mem[{ri, cj}];
    v_q <= vec_mem[cj];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && item.cmd == CMD_VECTOR && item.final_element && n_eff != 6'd0) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (prod_end) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_valid && !mul_valid && !acc_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy  = 1'b1;
    issue = 1'b0;
    unique case (state)
      ST_IDLE:  busy  = 1'b0;
      ST_RUN:   issue = 1'b1;
      ST_DRAIN: ;
      default:  busy  = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!issue) begin
      ri <= '0;
      cj <= '0;
    end else if (row_end) begin
      cj <= '0;
      ri <= ri + 1'b1;
    end else begin
      cj <= cj + 1'b1;
    end
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid  <= 1'b0;
      mul_valid <= 1'b0;
      acc_done  <= 1'b0;
    end else begin
      rd_valid  <= issue;
      mul_valid <= rd_valid;
      acc_done  <= mul_valid && mul_last;
    end
  end

  always_ff @(posedge clk) begin
    rd_first  <= (cj == '0);
    rd_last   <= row_end;
    rd_row    <= 5'(ri);
    mul_first <= rd_first;
    mul_last  <= rd_last;
    mul_row   <= rd_row;
    mul_p     <= prod_w;
  end

  assign prod_w = m_q * v_q;

  // a row that overflows the accumulator sticks at the extreme of that sign
  assign base     = mul_first ? '0 : acc;
  assign base_pos = mul_first ? 1'b0 : stuck_pos;
  assign base_neg = mul_first ? 1'b0 : stuck_neg;
  assign sum      = base + mul_p;

  always_comb begin
    acc_next       = base;
    stuck_pos_next = base_pos;
    stuck_neg_next = base_neg;
    if (!base_pos && !base_neg) begin
      if (!base[63] && !mul_p[63] && sum[63]) begin
        stuck_pos_next = 1'b1;
      end else if (base[63] && mul_p[63] && !sum[63]) begin
        stuck_neg_next = 1'b1;
      end else begin
        acc_next = sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mul_valid) begin
      acc_row   <= mul_row;
      acc_final <= mul_last && (6'(mul_row) == n_last);
      stuck_pos <= stuck_pos_next;
      stuck_neg <= stuck_neg_next;
      acc       <= acc_next;
    end
  end

  always_comb begin
    priority if (stuck_pos) begin
      acc_fixed = A_MAX;
    end else if (stuck_neg) begin
      acc_fixed = A_MIN;
    end else begin
      acc_fixed = acc;
    end
  end

  assign shifted = acc_fixed >>> FRAC_BITS;
  assign clip_hi = shifted > Q_MAX;
  assign clip_lo = shifted < Q_MIN;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= acc_done;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_done) begin
      result.out_row   <= acc_row;
      result.saturated <= clip_hi || clip_lo;
      result.last_row  <= acc_final;
      priority if (clip_hi) begin
        result.product_value <= Q_MAX[31:0];
      end else if (clip_lo) begin
        result.product_value <= Q_MIN[31:0];
      end else begin
        result.product_value <= shifted[31:0];
      end
    end
  end

  `DMVM_ASSERT_NOW(a_strobe_in_product, result_strobe, busy, "result word outside a product")
  `DMVM_ASSERT_NEXT(a_final_starts,
                    accept && item.cmd == CMD_VECTOR && item.final_element && n_eff != 6'd0,
                    state == ST_RUN, "final element did not start product")
  `DMVM_ASSERT_NEXT(a_last_row_ends, result_strobe && result.last_row, !result_strobe,
                    "word after last row")
  `DMVM_ASSERT_NOW(a_sat_clipped, result_strobe && result.saturated,
                   result.product_value == 32'sh7FFF_FFFF ||
                   result.product_value == 32'sh8000_0000,
                   "saturated word not at a limit")

endmodule

`default_nettype wire

// ===== dv/dmvm_product_checker.sv =====
`timescale 1ns / 1ps

module dmvm_product_checker #(
  parameter int MAX_SIZE  = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  dmvm_pkg::in_word_t  item,
  input  logic                result_strobe,
  input  dmvm_pkg::out_word_t result,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [5:0]          cfg_data,
  output int                  fail_count,
  output int                  rows_pending
);
  import dmvm_pkg::*;

  localparam longint ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint ACC_MIN = -ACC_MAX - 1;
  localparam longint CLIP_HI = 64'sd2147483647;
  localparam longint CLIP_LO = -64'sd2147483648;

  logic signed [31:0] coeff_mem [MAX_SIZE*MAX_SIZE];
  logic signed [31:0] vec_mem [MAX_SIZE];
  logic [5:0]         size_reg;
  out_word_t          expected_rows [$];
  int                 mismatch_count = 0;

  // One row of y = M*x; a 64-bit overflow pins the sum at that sign's extreme.
  function automatic out_word_t row_dot_product(int n, int r);
    longint    acc;
    longint    p;
    longint    shifted;
    int        stuck;
    out_word_t w;
    acc = 0;
    stuck = 0;
    for (int j = 0; j < n; j++) begin
      p = longint'(coeff_mem[r*MAX_SIZE + j]) * longint'(vec_mem[j]);
      if (stuck == 0) begin
        if (p > 0 && acc > ACC_MAX - p) stuck = 1;
        else if (p < 0 && acc < ACC_MIN - p) stuck = -1;
        else acc += p;
      end
    end
    if (stuck > 0) acc = ACC_MAX;
    else if (stuck < 0) acc = ACC_MIN;
    shifted = acc >>> FRAC_BITS;
    w.out_row = r[4:0];
    w.saturated = 1'b0;
    if (shifted > CLIP_HI) begin
      w.product_value = 32'sh7FFF_FFFF;
      w.saturated = 1'b1;
    end else if (shifted < CLIP_LO) begin
      w.product_value = 32'sh8000_0000;
      w.saturated = 1'b1;
    end else begin
      w.product_value = shifted[31:0];
    end
    w.last_row = (r == n - 1);
    return w;
  endfunction

  task automatic flag_error(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("[%0t] %s", $realtime, msg);
  endtask

  always @(posedge clk) begin : watch
    out_word_t want;
    int        n;
    if (rst) begin
      size_reg = SIZE_RESET;
      expected_rows.delete();
    end else begin
      if (cfg_valid && cfg_ready) size_reg = cfg_data;

      if (result_strobe) begin
        if (expected_rows.size() == 0) begin
          flag_error($sformatf("unexpected word: row %0d value %0d sat %0b last %0b",
                               result.out_row, result.product_value, result.saturated,
                               result.last_row));
        end else begin
          want = expected_rows.pop_front();
          if (result.out_row !== want.out_row ||
              result.product_value !== want.product_value ||
              result.saturated !== want.saturated ||
              result.last_row !== want.last_row) begin
            flag_error($sformatf({"mismatch: exp row %0d value %0d sat %0b last %0b, ",
                                  "got row %0d value %0d sat %0b last %0b"},
                                 want.out_row, want.product_value, want.saturated,
                                 want.last_row, result.out_row, result.product_value,
                                 result.saturated, result.last_row));
          end
        end
      end

      if (start && !busy) begin
        if (item.cmd == CMD_MATRIX) begin
          if (item.row_index < MAX_SIZE && item.col_index < MAX_SIZE)
            coeff_mem[item.row_index*MAX_SIZE + item.col_index] = item.data_value;
        end else begin
          if (item.col_index < MAX_SIZE) vec_mem[item.col_index] = item.data_value;
          if (item.final_element) begin
            n = size_reg;
            if (n > MAX_SIZE) n = MAX_SIZE;
            if (n > 32) n = 32;
            for (int r = 0; r < n; r++) expected_rows.push_back(row_dot_product(n, r));
          end
        end
      end
    end
    fail_count <= mismatch_count;
    rows_pending <= expected_rows.size();
  end

endmodule

// ===== dv/dense_matrix_vector_multiply_unit_tb.sv =====
`timescale 1ns / 1ps

module dense_matrix_vector_multiply_unit_tb;
  import dmvm_pkg::*;

  localparam int LIMIT        = 300000;
  localparam int TARGET_ITEMS = 170;
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  logic       clk = 1'b0;
  logic       rst;
  logic       start;
  logic       busy;
  in_word_t   item;
  logic       result_strobe;
  out_word_t  result;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [5:0] cfg_data;
  int         fail_count;
  int         rows_pending;
  int         cycles = 0;
  int         sent;
  int         idle_max;
  int         size_now;
  bit         m_done [1024];
  bit         v_done [32];

  always #5 clk = ~clk;

  dense_matrix_vector_multiply_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_strobe(result_strobe),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  dmvm_product_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_strobe(result_strobe),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .rows_pending (rows_pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("dense_matrix_vector_multiply_unit_tb: done, errors");
      $finish;
    end
  end

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0: return Q_MAX;
          1: return Q_MIN;
          2: return 32'sd0;
          3: return -32'sd1;
          default: return 32'sh0001_0000;
        endcase
      end
      1: return $urandom;
      default: return int'($urandom_range(0, 1 << 20)) - (1 << 19);
    endcase
  endfunction

  // Leaves start high after the handshake so back-to-back words need no gap.
  task automatic push_word(in_word_t w);
    int gap;
    gap = $urandom_range(0, idle_max);
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item = w;
    start = 1'b1;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic put_entry(int r, int c, logic signed [31:0] v, logic fin);
    in_word_t w;
    w.cmd = CMD_MATRIX;
    w.row_index = r[4:0];
    w.col_index = c[4:0];
    w.data_value = v;
    w.final_element = fin;
    m_done[r*32 + c] = 1'b1;
    push_word(w);
  endtask

  task automatic put_elem(int c, logic signed [31:0] v, logic fin);
    in_word_t w;
    w.cmd = CMD_VECTOR;
    w.row_index = 5'($urandom_range(0, 31));
    w.col_index = c[4:0];
    w.data_value = v;
    w.final_element = fin;
    v_done[c] = 1'b1;
    push_word(w);
  endtask

  // True once every entry that a product of size n reads holds a value.
  function automatic bit ready_for(int n);
    for (int i = 0; i < n; i++) begin
      if (!v_done[i]) return 1'b0;
      for (int j = 0; j < n; j++)
        if (!m_done[i*32 + j]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Stray writes, ignored final marks, and early product starts.
  task automatic noise();
    if ($urandom_range(0, 4) != 0) return;
    case ($urandom_range(0, 2))
      0: put_entry($urandom_range(0, 31), $urandom_range(0, 31), pick_value(),
                   1'($urandom_range(0, 1)));
      1: put_elem($urandom_range(0, 31), pick_value(), 1'b0);
      default: put_elem($urandom_range(0, 31), pick_value(), ready_for(size_now));
    endcase
  endtask

  task automatic load_matrix(int n, bit every);
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        noise();
        if (every || !m_done[i*32 + j] || $urandom_range(0, 2) == 0)
          put_entry(i, j, pick_value(), 1'($urandom_range(0, 1)));
      end
  endtask

  task automatic finish_vector(int n);
    for (int j = 0; j < n; j++) begin
      noise();
      if (!v_done[j] || $urandom_range(0, 2) == 0) put_elem(j, pick_value(), 1'b0);
    end
    put_elem($urandom_range(0, 31), pick_value(), 1'b1);
  endtask

  // Drop start, then wait for all rows to drain and the block to go idle.
  task automatic settle();
    @(negedge clk) start = 1'b0;
    @(posedge clk);
    while (rows_pending != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_size(int n);
    settle();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = n[5:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk) cfg_valid = 1'b0;
    size_now = (n > 32) ? 32 : n;
  endtask

  initial begin
    int n;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    idle_max = 12;
    size_now = 32;
    sent = 0;
    repeat (12) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // 1x1: largest positive product, then most negative squared
    write_size(1);
    put_entry(0, 0, Q_MAX, 1'b0);
    put_elem(0, Q_MAX, 1'b1);
    put_entry(0, 0, Q_MIN, 1'b1);
    put_elem(0, Q_MIN, 1'b1);

    // 2x2 of most negative values: sum overflows positive
    write_size(2);
    put_entry(0, 1, Q_MIN, 1'b0);
    put_entry(1, 0, Q_MIN, 1'b0);
    put_entry(1, 1, Q_MIN, 1'b0);
    put_elem(1, Q_MIN, 1'b1);

    // 3x3: three near -2^62 products overflow negative; unused far entries
    write_size(3);
    put_entry(0, 2, Q_MIN, 1'b0);
    put_entry(1, 2, Q_MIN, 1'b0);
    put_entry(2, 0, Q_MIN, 1'b0);
    put_entry(2, 1, Q_MIN, 1'b0);
    put_entry(2, 2, Q_MIN, 1'b0);
    put_entry(31, 31, pick_value(), 1'b0);
    put_elem(31, pick_value(), 1'b0);
    put_elem(0, Q_MAX, 1'b0);
    put_elem(1, Q_MAX, 1'b0);
    put_elem(2, Q_MAX, 1'b1);

    // floor rounding of a tiny negative product
    write_size(1);
    put_entry(0, 0, -32'sd1, 1'b0);
    put_elem(0, 32'sd1, 1'b1);

    // zero size: a product with no rows
    write_size(0);
    put_elem(4, pick_value(), 1'b1);

    while (sent < TARGET_ITEMS) begin
      if ($urandom_range(0, 1) == 1) begin
        n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
        write_size(n);
      end
      idle_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
      load_matrix(size_now, 1'b0);
      finish_vector(size_now);
    end
    settle();

    if (fail_count == 0 && rows_pending == 0)
      $display("dense_matrix_vector_multiply_unit_tb: done, clean");
    else
      $display("dense_matrix_vector_multiply_unit_tb: done, errors");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/dmvm_pkg.sv
design/dense_matrix_vector_multiply_unit.sv
dv/dmvm_product_checker.sv
dv/dense_matrix_vector_multiply_unit_tb.sv
